### src/binary_search_group_aggregator_core_macros.svh
// Assertion macros used by the checker file of the group aggregator.
`ifndef BINARY_SEARCH_GROUP_AGGREGATOR_CORE_MACROS_SVH
`define BINARY_SEARCH_GROUP_AGGREGATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSGA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("group aggregator check failed");

// Next-cycle implication, disabled while reset is high.
`define BSGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("group aggregator check failed");

`endif

### src/bsga_pkg.sv
// Package with sizes, codes and shared types of the group aggregator.
`timescale 1ns / 1ps

package bsga_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);

   localparam int GCOUNT_W = 17;
   localparam int GIDX_W   = 16;
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 32;
   localparam int SUM_W    = 64;
   localparam int CS_W     = COUNT_W + SUM_W;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_AGG   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] n;
   } srch_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] lo;
   } srch_rsp_type;

endpackage

### src/bsga_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bsga_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bsga_search.sv
// Lower-bound search sequencer: one key probe and one compare per step.
`timescale 1ns / 1ps

module bsga_search import bsga_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  srch_req_type       srch_req,
   input  logic [KEY_W-1:0]   key,
   input  logic [KEY_W-1:0]   rd_data,
   output logic [IDX_W-1:0]   rd_addr,
   output srch_rsp_type       srch_rsp
);

   typedef enum logic [2:0] {
      SR_IDLE  = 3'b001,
      SR_PROBE = 3'b010,
      SR_CMP   = 3'b100
   } sr_state_type;

   sr_state_type     state_ff, state_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] half;
   logic [CNT_W-1:0] probe;

   assign half    = len_ff >> 1;
   assign probe   = lo_ff + half;
   assign rd_addr = probe[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      len_in   = len_ff;
      case (state_ff)
         SR_IDLE: begin
            if (srch_req.start) begin
               lo_in    = '0;
               len_in   = srch_req.n;
               state_in = SR_PROBE;
            end
         end
         SR_PROBE: begin
            // address is out to the key RAM; empty range ends the search
            state_in = (len_ff == '0) ? SR_IDLE : SR_CMP;
         end
         SR_CMP: begin
            if (rd_data < key) begin
               lo_in  = probe + CNT_W'(1);
               len_in = len_ff - half - CNT_W'(1);
            end else begin
               len_in = half;
            end
            state_in = SR_PROBE;
         end
         default: begin
            state_in = SR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      len_ff <= len_in;
   end

   assign srch_rsp.done = (state_ff == SR_PROBE) && (len_ff == '0);
   assign srch_rsp.lo   = lo_ff;

endmodule

### src/binary_search_group_aggregator_core.sv
// Top level of the group-by count/sum aggregator over a sorted key table.
`timescale 1ns / 1ps

// Group-by aggregator over a table of TABLE_DEPTH ascending group keys, each
// with a 32-bit saturating count and a 64-bit wrapping sum. Every request
// gives exactly one response. A load (command 0) or read (command 2) passes
// through ST_ACCESS, ST_READ, ST_LATCH and ST_REPLY from acceptance to the
// response appearing. An aggregate (command 1) runs a lower-bound binary
// search of up to P = floor(log2(n)) + 1 probes for n searched groups through
// one shared compare unit, each probe sending the key RAM address out and
// taking the registered read data back; it then passes through ST_FETCH and
// ST_MODIFY, which a dropped key skips. A clear (command 3) sweeps the
// count/sum RAM one entry per cycle. After reset the same sweep runs with
// req_tready low; csr writes are taken during it. The block works on one
// request at a time; a finished response sits in the output register so the
// next request can be accepted while it waits.
module binary_search_group_aggregator_core import bsga_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   // request channel
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [47:0]    req_tdata,   // key[31:0], group_index[47:32]
   input  logic [1:0]     req_tuser,   // command[1:0]
   // response channel
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [143:0]   rsp_tdata,   // hit_index[15:0], group_key[47:16],
                                       // group_count_value[79:48],
                                       // group_sum[143:80]
   output logic           rsp_tuser,   // miss
   // configuration: group_count
   input  logic           csr_we,
   input  logic [16:0]    csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_ACCESS = 9'b000000010,
      ST_READ   = 9'b000000100,
      ST_LATCH  = 9'b000001000,
      ST_SEARCH = 9'b000010000,
      ST_FETCH  = 9'b000100000,
      ST_MODIFY = 9'b001000000,
      ST_CLEAR  = 9'b010000000,
      ST_REPLY  = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;

   // latched request
   cmd_type             cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [GIDX_W-1:0]   gidx_ff, gidx_in;
   logic                in_range_ff, in_range_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   // clear sweep
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic                clr_reply_ff, clr_reply_in;

   // pending result, moved to the output register in ST_REPLY
   logic                res_miss_ff, res_miss_in;
   logic [GIDX_W-1:0]   res_hit_ff, res_hit_in;
   logic [KEY_W-1:0]    res_key_ff, res_key_in;
   logic [COUNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic [SUM_W-1:0]    res_sum_ff, res_sum_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_miss_ff, rsp_miss_in;
   logic [143:0]        rsp_data_ff, rsp_data_in;

   logic [GCOUNT_W-1:0] gcount_ff, gcount_in;
   logic [CNT_W-1:0]    n_search;

   // RAM ports
   logic                key_we;
   logic [IDX_W-1:0]    key_raddr;
   logic [KEY_W-1:0]    key_rd;
   logic                cs_we;
   logic [IDX_W-1:0]    cs_waddr;
   logic [CS_W-1:0]     cs_wdata;
   logic [CS_W-1:0]     cs_rd;

   // search unit
   srch_req_type        srch_req;
   srch_rsp_type        srch_rsp;
   logic [IDX_W-1:0]    srch_addr;

   // update arithmetic
   logic [COUNT_W-1:0]  cnt_old, cnt_new;
   logic [SUM_W-1:0]    sum_old, sum_new;

   logic                req_fire;
   logic                out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Clamp the searched length to the table depth.
   always_comb begin
      if (32'(gcount_ff) > DEPTH_U) begin
         n_search = CNT_W'(TABLE_DEPTH);
      end else begin
         n_search = CNT_W'(gcount_ff);
      end
   end

   assign srch_req.start = req_fire && (cmd_type'(req_tuser) == CMD_AGG);
   assign srch_req.n     = n_search;

   // Saturate the count, wrap the sum.
   assign cnt_old = cs_rd[COUNT_W-1:0];
   assign sum_old = cs_rd[CS_W-1:COUNT_W];
   assign cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + COUNT_W'(1);
   assign sum_new = sum_old + SUM_W'(key_ff);

   // RAM control: the search drives the key address only while it runs.
   assign key_raddr = (state_ff == ST_SEARCH) ? srch_addr : idx_ff;
   assign key_we    = (state_ff == ST_ACCESS) && (cmd_ff == CMD_LOAD) && in_range_ff;
   assign cs_we     = (state_ff == ST_CLEAR) || (state_ff == ST_MODIFY);
   assign cs_waddr  = (state_ff == ST_CLEAR) ? clr_ff : idx_ff;
   assign cs_wdata  = (state_ff == ST_CLEAR) ? '0 : {sum_new, cnt_new};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      gidx_in      = gidx_ff;
      in_range_in  = in_range_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      clr_reply_in = clr_reply_ff;
      res_miss_in  = res_miss_ff;
      res_hit_in   = res_hit_ff;
      res_key_in   = res_key_ff;
      res_cnt_in   = res_cnt_ff;
      res_sum_in   = res_sum_ff;
      gcount_in    = csr_we ? csr_wdata : gcount_ff;

      // drop the response once taken
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_miss_in  = rsp_miss_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in      = cmd_type'(req_tuser);
               key_in      = req_tdata[31:0];
               gidx_in     = req_tdata[47:32];
               in_range_in = 32'(req_tdata[47:32]) < DEPTH_U;
               idx_in      = IDX_W'(req_tdata[47:32]);
               case (cmd_type'(req_tuser))
                  CMD_LOAD, CMD_READ: begin
                     state_in = ST_ACCESS;
                  end
                  CMD_AGG: begin
                     state_in = ST_SEARCH;
                  end
                  CMD_CLEAR: begin
                     clr_in       = '0;
                     clr_reply_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            // key write happens here; read it back next cycle
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            res_miss_in = 1'b0;
            res_hit_in  = gidx_ff;
            if (in_range_ff) begin
               res_key_in = key_rd;
               res_cnt_in = cnt_old;
               res_sum_in = sum_old;
            end else begin
               res_key_in = '0;
               res_cnt_in = '0;
               res_sum_in = '0;
            end
            state_in = ST_REPLY;
         end
         ST_SEARCH: begin
            if (srch_rsp.done) begin
               if (srch_rsp.lo >= n_search) begin
                  // key above every searched key: drop it
                  res_miss_in = 1'b1;
                  res_hit_in  = '0;
                  res_key_in  = '0;
                  res_cnt_in  = '0;
                  res_sum_in  = '0;
                  state_in    = ST_REPLY;
               end else begin
                  idx_in   = srch_rsp.lo[IDX_W-1:0];
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            // write back and report the updated entry
            res_miss_in = 1'b0;
            res_hit_in  = GIDX_W'(idx_ff);
            res_key_in  = key_rd;
            res_cnt_in  = cnt_new;
            res_sum_in  = sum_new;
            state_in    = ST_REPLY;
         end
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               clr_in = '0;
               if (clr_reply_ff) begin
                  res_miss_in = 1'b0;
                  res_hit_in  = '0;
                  res_key_in  = '0;
                  res_cnt_in  = '0;
                  res_sum_in  = '0;
                  state_in    = ST_REPLY;
               end else begin
                  state_in = ST_IDLE;
               end
               clr_reply_in = 1'b0;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end
         ST_REPLY: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_miss_in  = res_miss_ff;
               rsp_data_in  = {res_sum_ff, res_cnt_ff, res_key_ff, res_hit_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gcount_ff    <= GCOUNT_W'(1);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
         gcount_ff    <= gcount_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      gidx_ff     <= gidx_in;
      in_range_ff <= in_range_in;
      idx_ff      <= idx_in;
      res_miss_ff <= res_miss_in;
      res_hit_ff  <= res_hit_in;
      res_key_ff  <= res_key_in;
      res_cnt_ff  <= res_cnt_in;
      res_sum_ff  <= res_sum_in;
      rsp_miss_ff <= rsp_miss_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_miss_ff;
   assign rsp_tdata  = rsp_data_ff;

   bsga_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_addr (key_raddr),
      .rd_data (key_rd)
   );

   bsga_ram #(
      .WIDTH (CS_W),
      .DEPTH (TABLE_DEPTH)
   ) u_cs_ram (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (cs_waddr),
      .wr_data (cs_wdata),
      .rd_addr (idx_ff),
      .rd_data (cs_rd)
   );

   bsga_search u_search (
      .clock    (clock),
      .reset    (reset),
      .srch_req (srch_req),
      .key      (key_ff),
      .rd_data  (key_rd),
      .rd_addr  (srch_addr),
      .srch_rsp (srch_rsp)
   );

endmodule

### src/bsga_checker.sv
// Port-level checker for the group aggregator, bound to the top level.
`timescale 1ns / 1ps
`include "binary_search_group_aggregator_core_macros.svh"

module bsga_checker (
   input logic           clock,
   input logic           reset,
   input logic           req_tvalid,
   input logic           req_tready,
   input logic           rsp_tvalid,
   input logic           rsp_tready,
   input logic [143:0]   rsp_tdata,
   input logic           rsp_tuser
);

   // a stalled response stays offered
   `BSGA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // one request at a time: busy right after an accept
   `BSGA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // the clearing pass after reset blocks requests
   `BSGA_ASSERT_IMPLY(a_clear_after_reset, clock, reset, $fell(reset), !req_tready)

   // a dropped key reports an all-zero payload
   `BSGA_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)

endmodule

bind binary_search_group_aggregator_core bsga_checker u_checker (.*);
